[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[design/smbp_pkg.sv]
// ----------------------------------------------------------------------------
// smbp_pkg
// shared types and constants of the sha message block padder
// ----------------------------------------------------------------------------
package smbp_pkg;

  localparam int CMD_FIFO_DEPTH = 4;

  localparam logic [1:0]  MODE_SHA256   = 2'd1;
  localparam logic [1:0]  MODE_SHA512   = 2'd2;
  localparam logic [1:0]  HASH_MODE_RST = MODE_SHA256;

  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [60:0] MAX_COUNT     = 61'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [6:0]  LAST_POS_SHORT = 7'd63;
  localparam logic [6:0]  LAST_POS_LONG  = 7'd127;
  localparam logic [3:0]  LAST_IDX_SHORT = 4'd7;
  localparam logic [3:0]  LAST_IDX_LONG  = 4'd15;
  localparam logic [3:0]  SPILL_IDX      = 4'd14;

  typedef logic [1:0] op_t;
  localparam op_t OP_WORD   = 2'd0;
  localparam op_t OP_OVF    = 2'd1;
  localparam op_t OP_FINISH = 2'd2;

  typedef struct packed {
    op_t         op;
    logic [63:0] word;
    logic [3:0]  idx;
    logic        first;
    logic        eob;
    logic        big;
    logic [60:0] len;
  } cmd_t;

endpackage

[design/smbp_front.sv]
// ----------------------------------------------------------------------------
// smbp_front
// accepts bytes and finish items, tracks message state, issues commands
// ----------------------------------------------------------------------------
module smbp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic            in_kind,
  input  logic [7:0]      in_data_byte,
  output logic            in_full,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_hash_mode,
  input  logic            fifo_full,
  output logic            cmd_push,
  output smbp_pkg::cmd_t  cmd
);
  import smbp_pkg::*;

  logic [1:0]  mode_r;
  logic [6:0]  bib_r, bib_nxt;
  logic [60:0] count_r, count_nxt;
  logic [55:0] partial_r, partial_nxt;
  logic        first_r, first_nxt;

  logic        accept;
  logic        big;
  logic [6:0]  last_pos;
  logic [63:0] word;
  logic [5:0]  shamt;

  assign cfg_ready = 1'b1;
  assign in_full   = fifo_full;
  assign accept    = in_push && !fifo_full;
  assign big       = (mode_r == MODE_SHA512);
  assign last_pos  = big ? LAST_POS_LONG : LAST_POS_SHORT;
  assign word      = {partial_r, in_data_byte};
  assign shamt     = {3'd7 - bib_r[2:0], 3'b000};

  always_comb begin
    bib_nxt     = bib_r;
    count_nxt   = count_r;
    partial_nxt = partial_r;
    first_nxt   = first_r;
    cmd_push    = 1'b0;
    cmd.op      = OP_WORD;
    cmd.word    = word;
    cmd.idx     = bib_r[6:3];
    cmd.first   = first_r;
    cmd.eob     = (bib_r == last_pos);
    cmd.big     = big;
    cmd.len     = count_r;
    if (accept) begin
      if (in_kind) begin
        // finish: pad byte closes the current word, back side emits the rest
        cmd_push    = 1'b1;
        cmd.op      = OP_FINISH;
        cmd.word    = {partial_r, PAD_BYTE} << shamt;
        cmd.eob     = (bib_r[6:3] == last_pos[6:3]);
        bib_nxt     = '0;
        count_nxt   = '0;
        partial_nxt = '0;
        first_nxt   = 1'b1;
      end else if (count_r == MAX_COUNT) begin
        cmd_push = 1'b1;
        cmd.op   = OP_OVF;
      end else begin
        count_nxt = count_r + 61'd1;
        if (bib_r[2:0] == 3'd7) begin
          cmd_push    = 1'b1;
          partial_nxt = '0;
          if (bib_r == last_pos) begin
            bib_nxt   = '0;
            first_nxt = 1'b0;
          end else begin
            bib_nxt = bib_r + 7'd1;
          end
        end else begin
          partial_nxt = word[55:0];
          bib_nxt     = bib_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= HASH_MODE_RST;
      bib_r     <= '0;
      count_r   <= '0;
      partial_r <= '0;
      first_r   <= 1'b1;
    end else if (cfg_valid) begin
      mode_r    <= cfg_hash_mode;
      bib_r     <= '0;
      count_r   <= '0;
      partial_r <= '0;
      first_r   <= 1'b1;
    end else begin
      bib_r     <= bib_nxt;
      count_r   <= count_nxt;
      partial_r <= partial_nxt;
      first_r   <= first_nxt;
    end
  end

endmodule

[design/smbp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// smbp_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module smbp_cmd_fifo #(
  parameter int DEPTH = smbp_pkg::CMD_FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  smbp_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output smbp_pkg::cmd_t  pop_cmd,
  output logic            full,
  output logic            empty
);
  import smbp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[design/smbp_back.sv]
// ----------------------------------------------------------------------------
// smbp_back
// executes commands, sequences padding words, holds the result register
// ----------------------------------------------------------------------------
module smbp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  smbp_pkg::cmd_t  cmd,
  input  logic            fifo_empty,
  output logic            fifo_pop,
  output logic            busy,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [63:0]     out_block_word,
  output logic [3:0]      out_word_index,
  output logic            out_first_block,
  output logic            out_end_of_block,
  output logic            out_end_of_message,
  output logic            out_status
);
  import smbp_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        first_r, first_nxt;
  logic        spill_r, spill_nxt;
  logic        big_r, big_nxt;
  logic [60:0] len_r, len_nxt;

  logic        valid_r, valid_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  oidx_r, oidx_nxt;
  logic        ofirst_r, ofirst_nxt;
  logic        eob_r, eob_nxt;
  logic        eom_r, eom_nxt;
  logic        stat_r, stat_nxt;

  logic        load;
  logic [3:0]  last_idx;

  assign load      = !valid_r || out_pop;
  assign last_idx  = big_r ? LAST_IDX_LONG : LAST_IDX_SHORT;
  assign busy      = busy_r;
  assign out_empty = !valid_r;

  assign out_block_word     = word_r;
  assign out_word_index     = oidx_r;
  assign out_first_block    = ofirst_r;
  assign out_end_of_block   = eob_r;
  assign out_end_of_message = eom_r;
  assign out_status         = stat_r;

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    spill_nxt  = spill_r;
    big_nxt    = big_r;
    len_nxt    = len_r;
    valid_nxt  = valid_r;
    word_nxt   = word_r;
    oidx_nxt   = oidx_r;
    ofirst_nxt = ofirst_r;
    eob_nxt    = eob_r;
    eom_nxt    = eom_r;
    stat_nxt   = stat_r;
    fifo_pop   = 1'b0;
    if (load) begin
      if (busy_r) begin
        valid_nxt  = 1'b1;
        oidx_nxt   = idx_r;
        ofirst_nxt = first_r;
        stat_nxt   = 1'b0;
        if (idx_r == last_idx && !spill_r) begin
          // length word closes the message
          word_nxt = {len_r, 3'b000};
          eob_nxt  = 1'b1;
          eom_nxt  = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          word_nxt = '0;
          eob_nxt  = (idx_r == last_idx);
          eom_nxt  = 1'b0;
          if (idx_r == last_idx) begin
            idx_nxt   = '0;
            first_nxt = 1'b0;
            spill_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end else if (!fifo_empty) begin
        fifo_pop   = 1'b1;
        valid_nxt  = 1'b1;
        word_nxt   = cmd.word;
        oidx_nxt   = cmd.idx;
        ofirst_nxt = cmd.first;
        eob_nxt    = cmd.eob;
        eom_nxt    = 1'b0;
        stat_nxt   = 1'b0;
        unique case (cmd.op)
          OP_WORD: begin
          end
          OP_FINISH: begin
            busy_nxt  = 1'b1;
            idx_nxt   = cmd.eob ? 4'd0 : cmd.idx + 4'd1;
            first_nxt = cmd.eob ? 1'b0 : cmd.first;
            spill_nxt = cmd.big && (cmd.idx == SPILL_IDX);
            big_nxt   = cmd.big;
            len_nxt   = cmd.len;
          end
          default: begin
            word_nxt   = '0;
            oidx_nxt   = '0;
            ofirst_nxt = 1'b0;
            eob_nxt    = 1'b0;
            stat_nxt   = 1'b1;
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    first_r  <= first_nxt;
    spill_r  <= spill_nxt;
    big_r    <= big_nxt;
    len_r    <= len_nxt;
    word_r   <= word_nxt;
    oidx_r   <= oidx_nxt;
    ofirst_r <= ofirst_nxt;
    eob_r    <= eob_nxt;
    eom_r    <= eom_nxt;
    stat_r   <= stat_nxt;
  end

endmodule

[design/sha_message_block_padder_core.sv]
// ----------------------------------------------------------------------------
// sha_message_block_padder_core
// builds SHA-1/SHA-256/SHA-512 message blocks with padding and length
// ----------------------------------------------------------------------------
// Message bytes are accepted one per cycle while in_full is low; every eighth
// byte yields one 64-bit block word. A finish item yields the padding run of
// up to 18 words, produced one word per cycle by the back-end sequencer while
// out_pop keeps the result register free. A small command queue between the
// byte front end and the sequencer lets new bytes of the next message be
// taken while a padding run is still draining. The user must write hash_mode
// through the cfg channel only while the block is idle; the block does not
// enforce this. A write restarts the message.
module sha_message_block_padder_core #(
  parameter int CMD_DEPTH = smbp_pkg::CMD_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_block_word,
  output logic [3:0]  out_word_index,
  output logic        out_first_block,
  output logic        out_end_of_block,
  output logic        out_end_of_message,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_hash_mode
);
  import smbp_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic back_busy;

  smbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_kind       (in_kind),
    .in_data_byte  (in_data_byte),
    .in_full       (in_full),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_hash_mode (cfg_hash_mode),
    .fifo_full     (fifo_full),
    .cmd_push      (fifo_push),
    .cmd           (push_cmd)
  );

  smbp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  smbp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (pop_cmd),
    .fifo_empty         (fifo_empty),
    .fifo_pop           (fifo_pop),
    .busy               (back_busy),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_block_word     (out_block_word),
    .out_word_index     (out_word_index),
    .out_first_block    (out_first_block),
    .out_end_of_block   (out_end_of_block),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status)
  );

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_no_overflow, clk, rst_n, fifo_push && fifo_full, "command queue overflow")
  `ASSERT_NEVER(a_fifo_no_underflow, clk, rst_n, fifo_pop && fifo_empty, "command queue underflow")
  `ASSERT_NEVER(a_pop_while_busy, clk, rst_n, fifo_pop && back_busy, "command taken mid padding run")
  `ASSERT_PROP(a_eom_ends_block, clk, rst_n, (!out_empty && out_end_of_message) |-> (out_end_of_block && !out_status), "end of message not at end of block")

endmodule

[sim/tb_sha_message_block_padder_core.sv]
// ----------------------------------------------------------------------------
// tb_sha_message_block_padder_core
// self-checking testbench of the sha message block padder
// ----------------------------------------------------------------------------
// Message bytes and finish items go in through the push/full queue port. An
// in-bench padding model predicts every block word that each transfer should
// produce. Each popped word is compared field by field with the oldest
// prediction. A short table of directed items covers the three hash modes,
// mode code 3, empty messages and abandoning a message by a mode write. It is
// followed by random messages with short, spill-range and long lengths,
// trimmed to a fixed item budget per phase. Idling on the sender and receiver
// sides is varied across three phases.
module tb_sha_message_block_padder_core;
  import smbp_pkg::*;

  localparam logic [1:0] MODE_SHA1      = 2'd0;
  localparam logic [1:0] MODE_SHA256_AL = 2'd3;
  localparam logic       KIND_DATA      = 1'b0;
  localparam logic       KIND_FINISH    = 1'b1;
  localparam int         SETTLE_CYCLES  = 64;
  localparam int         FIRST_PHASE_ITEMS = 64;
  localparam int         PHASE_ITEMS    = 22;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  idx;
    logic        first;
    logic        eob;
    logic        eom;
    logic        status;
  } pad_word_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_FINISH, ROW_MODE} row_op_t;

  typedef struct packed {
    row_op_t   op;
    logic [7:0] val;
    logic      typed;
    pad_word_t want;
  } stim_row_t;

  localparam pad_word_t NO_WORD = '0;
  localparam int N_DIR = 27;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic        in_full;
  logic        in_kind      = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_empty;
  logic        out_pop      = 1'b0;
  logic [63:0] out_block_word;
  logic [3:0]  out_word_index;
  logic        out_first_block;
  logic        out_end_of_block;
  logic        out_end_of_message;
  logic        out_status;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_hash_mode = 2'd0;

  // padding model state
  logic [1:0]  mode_q;
  logic [7:0]  blk_fill;
  logic [60:0] msg_bytes;
  logic [55:0] part_word;
  logic        first_q;

  pad_word_t fresh_words[$];
  pad_word_t pending_words[$];

  int err_count     = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int mode_writes   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_FINISH, 8'h00, 1'b1, '{64'h0, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_BYTE,   8'h00, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hFF, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h01, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h80, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h7F, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hFE, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hAA, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h55, 1'b1, '{64'h00FF01807FFEAA55, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{ROW_FINISH, 8'hFF, 1'b1, '{64'h40, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_MODE,   {6'd0, MODE_SHA512}, 1'b0, NO_WORD},
    '{ROW_FINISH, 8'h00, 1'b1, '{64'h0, 4'd15, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_BYTE,   8'hFF, 1'b0, NO_WORD},
    '{ROW_FINISH, 8'h00, 1'b1, '{64'h8, 4'd15, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_MODE,   {6'd0, MODE_SHA1}, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h00, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hFF, 1'b0, NO_WORD},
    '{ROW_FINISH, 8'h00, 1'b1, '{64'h10, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_MODE,   {6'd0, MODE_SHA256_AL}, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hA5, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h3C, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'hC3, 1'b0, NO_WORD},
    // mode write drops the partial message
    '{ROW_MODE,   {6'd0, MODE_SHA256}, 1'b0, NO_WORD},
    '{ROW_FINISH, 8'h00, 1'b1, '{64'h0, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_MODE,   {6'd0, MODE_SHA256_AL}, 1'b0, NO_WORD},
    '{ROW_BYTE,   8'h5A, 1'b0, NO_WORD},
    '{ROW_FINISH, 8'h00, 1'b0, NO_WORD}
  };

  sha_message_block_padder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_block_word    (out_block_word),
    .out_word_index    (out_word_index),
    .out_first_block   (out_first_block),
    .out_end_of_block  (out_end_of_block),
    .out_end_of_message(out_end_of_message),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_hash_mode     (cfg_hash_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int block_bytes();
    return (mode_q == MODE_SHA512) ? 128 : 64;
  endfunction

  function automatic int len_field_bytes();
    return (mode_q == MODE_SHA512) ? 16 : 8;
  endfunction

  task automatic clear_message();
    blk_fill  = 8'd0;
    msg_bytes = '0;
    part_word = '0;
    first_q   = 1'b1;
  endtask

  task automatic pack_byte(input logic [7:0] b);
    logic [7:0]  pos;
    logic [7:0]  nxt;
    logic [63:0] w;
    pad_word_t   r;
    pos = blk_fill;
    w   = {part_word, b};
    nxt = pos + 8'd1;
    if (nxt[2:0] == 3'd0) begin
      r.word   = w;
      r.idx    = pos[6:3];
      r.first  = first_q;
      r.eob    = (nxt == block_bytes());
      r.eom    = 1'b0;
      r.status = 1'b0;
      fresh_words.push_back(r);
      part_word = '0;
      if (r.eob) begin
        blk_fill = 8'd0;
        first_q  = 1'b0;
      end else begin
        blk_fill = nxt;
      end
    end else begin
      part_word = w[55:0];
      blk_fill  = nxt;
    end
  endtask

  task automatic pad_predict(input logic kind, input logic [7:0] data);
    logic [63:0] bits;
    pad_word_t   r;
    if (kind == KIND_DATA) begin
      if (msg_bytes >= MAX_COUNT) begin
        r = '0;
        r.status = 1'b1;
        fresh_words.push_back(r);
      end else begin
        msg_bytes = msg_bytes + 61'd1;
        pack_byte(data);
      end
    end else begin
      bits = {msg_bytes, 3'b000};
      pack_byte(PAD_BYTE);
      // length field does not fit: finish this block with zeros
      if (blk_fill != 0 && blk_fill > block_bytes() - len_field_bytes()) begin
        while (blk_fill != 0) pack_byte(8'h00);
      end
      while (blk_fill != block_bytes() - 8) pack_byte(8'h00);
      for (int i = 7; i >= 0; i--) pack_byte(bits[8*i +: 8]);
      r = fresh_words.pop_back();
      r.eom = 1'b1;
      fresh_words.push_back(r);
      clear_message();
    end
  endtask

  task automatic send_item(input logic kind, input logic [7:0] data, input logic typed,
                           input pad_word_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    do @(posedge clk); while (in_full);
    fresh_words.delete();
    pad_predict(kind, data);
    if (typed) begin
      void'(fresh_words.pop_back());
      fresh_words.push_back(want);
    end
    foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    in_push <= 1'b0;
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_hash_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_q = m;
    clear_message();
    mode_writes++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: check each transfer against the oldest prediction
  initial begin
    pad_word_t w;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_words.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word, expected none, actual %h", $time, out_block_word);
        end else begin
          w = pending_words.pop_front();
          check_field("block_word", w.word, out_block_word);
          check_field("word_index", 64'(w.idx), 64'(out_word_index));
          check_field("first_block", 64'(w.first), 64'(out_first_block));
          check_field("end_of_block", 64'(w.eob), 64'(out_end_of_block));
          check_field("end_of_message", 64'(w.eom), 64'(out_end_of_message));
          check_field("status", 64'(w.status), 64'(out_status));
          words_checked++;
        end
      end
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int len;
    int sel;
    int phase_items;
    int phase_budget;
    mode_q = HASH_MODE_RST;
    clear_message();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      case (dir_rows[i].op)
        ROW_MODE:   write_mode(dir_rows[i].val[1:0]);
        ROW_BYTE:   send_item(KIND_DATA, dir_rows[i].val, dir_rows[i].typed,
                              dir_rows[i].want);
        default:    send_item(KIND_FINISH, dir_rows[i].val, dir_rows[i].typed,
                              dir_rows[i].want);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 35 : 0;
      phase_budget  = (ph == 0) ? FIRST_PHASE_ITEMS : PHASE_ITEMS;
      phase_items = 0;
      while (phase_items < phase_budget) begin
        if ($urandom_range(0, 2) == 0) write_mode(2'($urandom_range(0, 3)));
        sel = (ph == 0 && phase_items == 0) ? 7 : $urandom_range(0, 9);
        // short, spill-range or long message, trimmed to what is left of the phase
        if (sel < 7) len = $urandom_range(0, 15);
        else if (sel < 9) len = $urandom_range(block_bytes() - len_field_bytes() - 1,
                                               block_bytes() - 1);
        else len = block_bytes() + $urandom_range(0, 9);
        if (len > phase_budget - phase_items - 1) len = phase_budget - phase_items - 1;
        repeat (len) send_item(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        phase_items += len + 1;
      end
    end

    in_push <= 1'b0;
    wait_drained();
    $display("run covered %0d items and %0d block words over %0d mode writes", items_sent,
             words_checked, mode_writes);
    $display("hash modes 0 to 3, empty, short and spilling messages, three idling mixes");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
